>>> design/bapf_pkg.sv
`default_nettype none

package bapf_pkg;

   // Operation codes carried in the mode field of a request.
   typedef enum logic [3:0] {
      MODE_ADD  = 4'd0,
      MODE_ADDC = 4'd1,
      MODE_SUBB = 4'd2,
      MODE_AND  = 4'd3,
      MODE_OR   = 4'd4,
      MODE_XOR  = 4'd5,
      MODE_INC  = 4'd6,
      MODE_DEC  = 4'd7,
      MODE_DA   = 4'd8,
      MODE_MUL  = 4'd9,
      MODE_DIV  = 4'd10,
      MODE_CPL  = 4'd11,
      MODE_CJNE = 4'd12,
      MODE_DJNZ = 4'd13,
      MODE_XCHD = 4'd14
   } mode_type;

   // Decimal adjust constants.
   localparam logic [3:0] BCD_DIGIT_MAX = 4'd9;
   localparam logic [7:0] DA_LOW_ADJ    = 8'h06;
   localparam logic [7:0] DA_HIGH_ADJ   = 8'h60;

   // One request: operation, operands and incoming flags.
   typedef struct packed {
      mode_type   mode;
      logic [7:0] first;
      logic [7:0] second;
      logic       carry_in;
      logic       aux_carry_in;
      logic       overflow_in;
   } req_type;

   // One response: result bytes, updated flags and branch indication.
   typedef struct packed {
      logic [7:0] result_first;
      logic [7:0] result_second;
      logic       carry_out;
      logic       aux_carry_out;
      logic       overflow_out;
      logic       taken;
   } rsp_type;

   // Contents of the middle pipeline stage.
   typedef struct packed {
      rsp_type    res;
      mode_type   mode;
      logic [7:0] first;
      logic [7:0] second;
      logic       carry_in;
      logic       aux_carry_in;
      logic [3:0] quot_hi;
      logic [7:0] div_rem;
   } mid_type;

endpackage

`default_nettype wire

>>> design/bapf_div4.sv
`default_nettype none

// Four steps of a restoring divider: one quotient bit per step.
module bapf_div4 (
   input  logic [7:0] rem_in,
   input  logic [3:0] bits_in,
   input  logic [7:0] divisor,
   output logic [7:0] rem_out,
   output logic [3:0] quot_out
);

   always_comb begin
      logic [8:0] trial;
      logic [7:0] rem;
      rem      = rem_in;
      quot_out = '0;
      trial    = '0;
      // Shift in the next dividend bit and subtract when the divisor fits.
      for (int i = 3; i >= 0; i--) begin
         trial = {rem, bits_in[i]};
         if (trial >= {1'b0, divisor}) begin
            trial       = trial - {1'b0, divisor};
            quot_out[i] = 1'b1;
         end
         rem = trial[7:0];
      end
      rem_out = rem;
   end

endmodule

`default_nettype wire

>>> design/bapf_arith.sv
`default_nettype none

// First execution stage: adder, subtractor, logic, multiply and the upper
// half of the division.
module bapf_arith
   import bapf_pkg::*;
(
   input  req_type req,
   output mid_type mid
);

   logic [7:0] div_rem;
   logic [3:0] quot_hi;

   // Upper quotient nibble starts from a zero partial remainder.
   bapf_div4 u_div_hi (
      .rem_in   (8'd0),
      .bits_in  (req.first[7:4]),
      .divisor  (req.second),
      .rem_out  (div_rem),
      .quot_out (quot_hi)
   );

   always_comb begin
      logic        cin;
      logic [8:0]  sum9;
      logic [7:0]  sum_lo7;
      logic [4:0]  sum_nib;
      logic [8:0]  dif9;
      logic [7:0]  dif_lo7;
      logic [4:0]  dif_nib;
      logic [15:0] prod;
      logic [7:0]  dec_val;
      rsp_type     res;

      // Add with optional carry; carries out of bits 3, 6 and 7.
      cin     = (req.mode == MODE_ADDC) ? req.carry_in : 1'b0;
      sum9    = {1'b0, req.first} + {1'b0, req.second} + {8'd0, cin};
      sum_lo7 = {1'b0, req.first[6:0]} + {1'b0, req.second[6:0]} + {7'd0, cin};
      sum_nib = {1'b0, req.first[3:0]} + {1'b0, req.second[3:0]} + {4'd0, cin};

      // Subtract with borrow; the top bit of each difference is the borrow.
      dif9    = {1'b0, req.first} - {1'b0, req.second} - {8'd0, req.carry_in};
      dif_lo7 = {1'b0, req.first[6:0]} - {1'b0, req.second[6:0]}
                - {7'd0, req.carry_in};
      dif_nib = {1'b0, req.first[3:0]} - {1'b0, req.second[3:0]}
                - {4'd0, req.carry_in};

      prod    = {8'd0, req.first} * {8'd0, req.second};
      dec_val = req.first - 8'd1;

      // Flags and bytes pass through unless the operation changes them.
      res.result_first  = req.first;
      res.result_second = req.second;
      res.carry_out     = req.carry_in;
      res.aux_carry_out = req.aux_carry_in;
      res.overflow_out  = req.overflow_in;
      res.taken         = 1'b0;

      unique case (req.mode)
         MODE_ADD, MODE_ADDC: begin
            res.result_first  = sum9[7:0];
            res.carry_out     = sum9[8];
            res.aux_carry_out = sum_nib[4];
            res.overflow_out  = sum_lo7[7] ^ sum9[8];
         end
         MODE_SUBB: begin
            res.result_first  = dif9[7:0];
            res.carry_out     = dif9[8];
            res.aux_carry_out = dif_nib[4];
            res.overflow_out  = dif_lo7[7] ^ dif9[8];
         end
         MODE_AND: res.result_first = req.first & req.second;
         MODE_OR:  res.result_first = req.first | req.second;
         MODE_XOR: res.result_first = req.first ^ req.second;
         MODE_INC: res.result_first = req.first + 8'd1;
         MODE_DEC: res.result_first = dec_val;
         MODE_DA:  ;
         MODE_MUL: begin
            res.result_first  = prod[7:0];
            res.result_second = prod[15:8];
            res.carry_out     = 1'b0;
            res.overflow_out  = |prod[15:8];
         end
         MODE_DIV: begin
            // Bytes are filled in by the next stage when the divisor is nonzero.
            res.carry_out    = 1'b0;
            res.overflow_out = (req.second == 8'd0);
         end
         MODE_CPL: res.result_first = ~req.first;
         MODE_CJNE: begin
            res.carry_out = (req.first < req.second);
            res.taken     = (req.first != req.second);
         end
         MODE_DJNZ: begin
            res.result_first = dec_val;
            res.taken        = (dec_val != 8'd0);
         end
         MODE_XCHD: begin
            res.result_first  = {req.first[7:4], req.second[3:0]};
            res.result_second = {req.second[7:4], req.first[3:0]};
         end
         default: ;
      endcase

      mid.res          = res;
      mid.mode         = req.mode;
      mid.first        = req.first;
      mid.second       = req.second;
      mid.carry_in     = req.carry_in;
      mid.aux_carry_in = req.aux_carry_in;
      mid.quot_hi      = quot_hi;
      mid.div_rem      = div_rem;
   end

endmodule

`default_nettype wire

>>> design/bapf_finish.sv
`default_nettype none

// Second execution stage: lower half of the division, decimal adjust and
// the final result selection.
module bapf_finish
   import bapf_pkg::*;
(
   input  mid_type mid,
   output rsp_type rsp
);

   logic [7:0] rem;
   logic [3:0] quot_lo;

   // Lower quotient nibble continues from the partial remainder.
   bapf_div4 u_div_lo (
      .rem_in   (mid.div_rem),
      .bits_in  (mid.first[3:0]),
      .divisor  (mid.second),
      .rem_out  (rem),
      .quot_out (quot_lo)
   );

   always_comb begin
      logic [8:0] adj;
      logic       da_cy;

      // Decimal adjust: low digit correction, then high digit correction.
      adj   = {1'b0, mid.first};
      da_cy = mid.carry_in;
      if ((mid.first[3:0] > BCD_DIGIT_MAX) || mid.aux_carry_in) begin
         adj   = adj + {1'b0, DA_LOW_ADJ};
         da_cy = da_cy | adj[8];
         adj   = {1'b0, adj[7:0]};
      end
      if (da_cy || (adj[7:4] > BCD_DIGIT_MAX)) begin
         adj   = adj + {1'b0, DA_HIGH_ADJ};
         da_cy = 1'b1;
      end

      rsp = mid.res;
      unique case (mid.mode)
         MODE_DA: begin
            rsp.result_first = adj[7:0];
            rsp.carry_out    = da_cy;
         end
         MODE_DIV: begin
            // A zero divisor leaves both bytes unchanged.
            if (mid.second != 8'd0) begin
               rsp.result_first  = {mid.quot_hi, quot_lo};
               rsp.result_second = rem;
            end
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

>>> design/byte_alu_with_psw_flags.sv
`default_nettype none

// Byte ALU with program status flags for an 8051-class core. Each request
// carries an operation code, two operand bytes and the CY, AC and OV flags;
// each response returns two result bytes, the updated flags and a branch
// indication for CJNE and DJNZ. The block accepts one request every clock
// while req_stall is low. A request passes through all three register
// stages before its response is offered. The three register stages are an
// input register, a stage holding the adder, multiplier and the upper four
// steps of the restoring divider, and an output register fed by the lower
// four divider steps and the decimal adjust logic. The divider's eight
// dependent steps set the depth of the pipeline. A stalled response holds
// the pipeline in place, and requests keep entering until every stage is
// full.
module byte_alu_with_psw_flags
   import bapf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type s1_req_ff;
   logic    s1_valid_ff;
   mid_type s2_mid_ff;
   logic    s2_valid_ff;
   rsp_type s3_rsp_ff;
   logic    s3_valid_ff;

   mid_type s2_mid_in;
   rsp_type s3_rsp_in;
   logic    adv1;
   logic    adv2;
   logic    adv3;

   // A stage advances when it is empty or when the stage after it moves.
   assign adv3      = !s3_valid_ff || !rsp_stall;
   assign adv2      = !s2_valid_ff || adv3;
   assign adv1      = !s1_valid_ff || adv2;
   assign req_stall = !adv1;

   bapf_arith u_arith (
      .req (s1_req_ff),
      .mid (s2_mid_in)
   );

   bapf_finish u_finish (
      .mid (s2_mid_ff),
      .rsp (s3_rsp_in)
   );

   // Valid bits of the three stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (adv1) s1_valid_ff <= req_valid;
         if (adv2) s2_valid_ff <= s1_valid_ff;
         if (adv3) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload registers move together with their valid bits.
   always_ff @(posedge clock) begin
      if (adv1) s1_req_ff <= req_data;
      if (adv2) s2_mid_ff <= s2_mid_in;
      if (adv3) s3_rsp_ff <= s3_rsp_in;
   end

   assign rsp_valid = s3_valid_ff;
   assign rsp_data  = s3_rsp_ff;

endmodule

`default_nettype wire
